// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== src/dfr_pkg.sv =====
// Types, constants and the field map of the multi-frame serial deframer.
package dfr_pkg;

   localparam int STATUS_LEN  = 24;
   localparam int RANGE_LEN   = 19;
   localparam int CHARGER_LEN = 8;

   localparam logic [3:0] STATUS_LAST_FIELD  = 4'd10;
   localparam logic [3:0] RANGE_LAST_FIELD   = 4'd7;
   localparam logic [3:0] CHARGER_LAST_FIELD = 4'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_STATUS_HEADER  = 3'd0;
   localparam logic [2:0] REG_STATUS_TAIL    = 3'd1;
   localparam logic [2:0] REG_RANGE_HEADER   = 3'd2;
   localparam logic [2:0] REG_RANGE_TAIL     = 3'd3;
   localparam logic [2:0] REG_CHARGER_HEADER = 3'd4;
   localparam logic [2:0] REG_CHARGER_TAIL   = 3'd5;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_RANGE   = 2'd1,
      KIND_CHARGER = 2'd2
   } frame_kind_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_RUN  = 1'b1
   } seq_state_type;

   typedef struct packed {
      logic [7:0] status_header;
      logic [7:0] status_tail;
      logic [7:0] range_header;
      logic [7:0] range_tail;
      logic [7:0] charger_header;
      logic [7:0] charger_tail;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      status_header:  8'd123,
      status_tail:    8'd125,
      range_header:   8'd250,
      range_tail:     8'd252,
      charger_header: 8'd124,
      charger_tail:   8'd127
   };

   typedef struct packed {
      logic charger_good;
      logic range_good;
      logic status_good;
   } done_type;

   typedef struct packed {
      logic           issue;
      frame_kind_type kind;
      logic [4:0]     hi_addr;
      logic [4:0]     lo_addr;
   } rd_req_type;

   typedef struct packed {
      logic [4:0] hi_addr;
      logic [4:0] lo_addr;
      logic       single;
      logic       last;
   } field_map_type;

   // Buffer positions of one field; a single field is a zero-extended byte at lo_addr.
   function automatic field_map_type field_map(frame_kind_type kind, logic [3:0] idx);
      field_map_type m;
      logic [4:0]    twice;
      twice = {idx, 1'b0};
      m = '0;
      unique case (kind)
         KIND_STATUS: begin
            if (idx == 4'd0) begin
               m.single  = 1'b1;
               m.lo_addr = 5'd1;
            end else begin
               m.hi_addr = twice;
               m.lo_addr = twice + 5'd1;
            end
            m.last = (idx == STATUS_LAST_FIELD);
         end
         KIND_RANGE: begin
            m.hi_addr = twice + 5'd1;
            m.lo_addr = twice + 5'd2;
            m.last    = (idx == RANGE_LAST_FIELD);
         end
         KIND_CHARGER: begin
            unique case (idx)
               4'd0: begin
                  m.hi_addr = 5'd1;
                  m.lo_addr = 5'd2;
               end
               4'd1: begin
                  m.single  = 1'b1;
                  m.lo_addr = 5'd3;
               end
               default: begin
                  m.single  = 1'b1;
                  m.lo_addr = 5'd4;
               end
            endcase
            m.last = (idx == CHARGER_LAST_FIELD);
         end
         default: begin
            m.last = 1'b1;
         end
      endcase
      return m;
   endfunction

endpackage

// ===== src/dfr_capture.sv =====
// Frame buffers, write positions and running block checks of the deframer.
module dfr_capture (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  logic [7:0]          rx_byte,
   input  dfr_pkg::cfg_type    cfg,
   input  dfr_pkg::rd_req_type rd,
   output dfr_pkg::done_type   done,
   output logic [7:0]          rd_hi,
   output logic [7:0]          rd_lo
);
   import dfr_pkg::*;

   logic [7:0] status_mem  [STATUS_LEN];
   logic [7:0] range_mem   [RANGE_LEN];
   logic [7:0] charger_mem [CHARGER_LEN];

   logic [4:0] st_pos_ff, st_pos_in, st_adv;
   logic [4:0] rg_pos_ff, rg_pos_in, rg_adv;
   logic [3:0] ch_pos_ff, ch_pos_in, ch_adv;
   logic [7:0] prev_ff;
   logic [7:0] st_acc_ff, st_acc_in, rg_acc_ff, rg_acc_in, ch_acc_ff, ch_acc_in;
   logic       st_chk_ff, st_chk_in, rg_chk_ff, rg_chk_in, ch_chk_ff, ch_chk_in;
   logic       st_start, rg_start, ch_start;
   logic       st_end, rg_end, ch_end;

   frame_kind_type rd_kind_ff;
   logic [7:0]     st_hi_ff, st_lo_ff, rg_hi_ff, rg_lo_ff, ch_hi_ff, ch_lo_ff;

   // A frame opens on its header right after the tail of the frame type before it.
   assign st_start = (rx_byte == cfg.status_header) && (prev_ff == cfg.charger_tail);
   assign rg_start = (rx_byte == cfg.range_header) && (prev_ff == cfg.status_tail);
   assign ch_start = (rx_byte == cfg.charger_header) && (prev_ff == cfg.range_tail);

   always_comb begin
      st_adv    = (st_start || st_pos_ff != '0) ? st_pos_ff + 5'd1 : '0;
      rg_adv    = (rg_start || rg_pos_ff != '0) ? rg_pos_ff + 5'd1 : '0;
      ch_adv    = (ch_start || ch_pos_ff != '0) ? ch_pos_ff + 4'd1 : '0;
      st_end    = (st_adv == 5'(STATUS_LEN));
      rg_end    = (rg_adv == 5'(RANGE_LEN));
      ch_end    = (ch_adv == 4'(CHARGER_LEN));
      st_pos_in = st_end ? '0 : st_adv;
      rg_pos_in = rg_end ? '0 : rg_adv;
      ch_pos_in = ch_end ? '0 : ch_adv;

      // The check byte sits at LEN-2 and covers every byte before it.
      if (st_pos_ff == '0) begin
         st_acc_in = rx_byte;
      end else if (st_pos_ff <= 5'(STATUS_LEN - 3)) begin
         st_acc_in = st_acc_ff ^ rx_byte;
      end else begin
         st_acc_in = st_acc_ff;
      end
      if (rg_pos_ff == '0) begin
         rg_acc_in = rx_byte;
      end else if (rg_pos_ff <= 5'(RANGE_LEN - 3)) begin
         rg_acc_in = rg_acc_ff ^ rx_byte;
      end else begin
         rg_acc_in = rg_acc_ff;
      end
      if (ch_pos_ff == '0) begin
         ch_acc_in = rx_byte;
      end else if (ch_pos_ff <= 4'(CHARGER_LEN - 3)) begin
         ch_acc_in = ch_acc_ff ^ rx_byte;
      end else begin
         ch_acc_in = ch_acc_ff;
      end

      st_chk_in = (st_pos_ff == 5'(STATUS_LEN - 2)) ? (st_acc_ff == rx_byte) : st_chk_ff;
      rg_chk_in = (rg_pos_ff == 5'(RANGE_LEN - 2)) ? (rg_acc_ff == rx_byte) : rg_chk_ff;
      ch_chk_in = (ch_pos_ff == 4'(CHARGER_LEN - 2)) ? (ch_acc_ff == rx_byte) : ch_chk_ff;

      done.status_good  = req_accept && st_end && st_chk_ff && (rx_byte == cfg.status_tail);
      done.range_good   = req_accept && rg_end && rg_chk_ff && (rx_byte == cfg.range_tail);
      done.charger_good = req_accept && ch_end && ch_chk_ff && (rx_byte == cfg.charger_tail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_pos_ff <= '0;
         rg_pos_ff <= '0;
         ch_pos_ff <= '0;
         prev_ff   <= '0;
         st_acc_ff <= '0;
         rg_acc_ff <= '0;
         ch_acc_ff <= '0;
         st_chk_ff <= 1'b0;
         rg_chk_ff <= 1'b0;
         ch_chk_ff <= 1'b0;
      end else if (req_accept) begin
         st_pos_ff <= st_pos_in;
         rg_pos_ff <= rg_pos_in;
         ch_pos_ff <= ch_pos_in;
         prev_ff   <= rx_byte;
         st_acc_ff <= st_acc_in;
         rg_acc_ff <= rg_acc_in;
         ch_acc_ff <= ch_acc_in;
         st_chk_ff <= st_chk_in;
         rg_chk_ff <= rg_chk_in;
         ch_chk_ff <= ch_chk_in;
      end
   end

   // Every byte lands in all three buffers at their current positions.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_mem[st_pos_ff]       <= rx_byte;
         range_mem[rg_pos_ff]        <= rx_byte;
         charger_mem[ch_pos_ff[2:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.issue) begin
         rd_kind_ff <= rd.kind;
      end
      if (rd.issue && rd.kind == KIND_STATUS) begin
         st_hi_ff <= status_mem[rd.hi_addr];
         st_lo_ff <= status_mem[rd.lo_addr];
      end
      if (rd.issue && rd.kind == KIND_RANGE) begin
         rg_hi_ff <= range_mem[rd.hi_addr];
         rg_lo_ff <= range_mem[rd.lo_addr];
      end
      if (rd.issue && rd.kind == KIND_CHARGER) begin
         ch_hi_ff <= charger_mem[rd.hi_addr[2:0]];
         ch_lo_ff <= charger_mem[rd.lo_addr[2:0]];
      end
   end

   always_comb begin
      unique case (rd_kind_ff)
         KIND_STATUS: begin
            rd_hi = st_hi_ff;
            rd_lo = st_lo_ff;
         end
         KIND_RANGE: begin
            rd_hi = rg_hi_ff;
            rd_lo = rg_lo_ff;
         end
         KIND_CHARGER: begin
            rd_hi = ch_hi_ff;
            rd_lo = ch_lo_ff;
         end
         default: begin
            rd_hi = '0;
            rd_lo = '0;
         end
      endcase
   end

endmodule

// ===== src/dfr_emit.sv =====
// Field sequencer and output register that turn good frames into result runs.
module dfr_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  dfr_pkg::done_type   done,
   output logic                busy,
   output dfr_pkg::rd_req_type rd,
   input  logic [7:0]          rd_hi,
   input  logic [7:0]          rd_lo,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_frame_kind,
   output logic [3:0]          rsp_field_index,
   output logic signed [15:0]  rsp_field_value,
   output logic                rsp_last
);
   import dfr_pkg::*;

   seq_state_type  state_ff, state_in;
   done_type       pend_ff, pend_in;
   logic [3:0]     idx_ff, idx_in;
   frame_kind_type cur_kind;
   field_map_type  fmap;
   logic           out_free, issue, load_rsp;

   logic           rd_valid_ff, rd_valid_in;
   frame_kind_type rd_kind_ff;
   logic [3:0]     rd_idx_ff;
   logic           rd_single_ff, rd_last_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   frame_kind_type rsp_kind_ff;
   logic [3:0]     rsp_idx_ff;
   logic [15:0]    rsp_value_ff;
   logic           rsp_last_ff;

   // Runs go out charger first, then distance, then status.
   always_comb begin
      priority if (pend_ff.charger_good) begin
         cur_kind = KIND_CHARGER;
      end else if (pend_ff.range_good) begin
         cur_kind = KIND_RANGE;
      end else begin
         cur_kind = KIND_STATUS;
      end
   end

   assign fmap     = field_map(cur_kind, idx_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = (state_ff == SEQ_RUN) && (!rd_valid_ff || out_free);
   assign load_rsp = out_free && rd_valid_ff;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_accept && done != '0) begin
               pend_in  = done;
               idx_in   = '0;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (issue) begin
               if (fmap.last) begin
                  idx_in = '0;
                  unique case (cur_kind)
                     KIND_CHARGER: pend_in.charger_good = 1'b0;
                     KIND_RANGE:   pend_in.range_good   = 1'b0;
                     default:      pend_in.status_good  = 1'b0;
                  endcase
                  if (pend_in == '0) begin
                     state_in = SEQ_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (out_free) begin
         rd_valid_in = 1'b0;
      end else begin
         rd_valid_in = rd_valid_ff;
      end
      rsp_valid_in = out_free ? rd_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         pend_ff      <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_kind_ff   <= cur_kind;
         rd_idx_ff    <= idx_ff;
         rd_single_ff <= fmap.single;
         rd_last_ff   <= fmap.last;
      end
      if (load_rsp) begin
         rsp_kind_ff  <= rd_kind_ff;
         rsp_idx_ff   <= rd_idx_ff;
         rsp_value_ff <= rd_single_ff ? {8'h00, rd_lo} : {rd_hi, rd_lo};
         rsp_last_ff  <= rd_last_ff;
      end
   end

   assign rd.issue   = issue;
   assign rd.kind    = cur_kind;
   assign rd.hi_addr = fmap.hi_addr;
   assign rd.lo_addr = fmap.lo_addr;

   assign busy            = (state_ff == SEQ_RUN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_kind  = rsp_kind_ff;
   assign rsp_field_index = rsp_idx_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== src/multi_frame_serial_deframer.sv =====
// Top level of the multi-frame serial deframer with its register port.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_rx_byte (8)
//   rsp      out        rsp_valid / rsp_stall   kind (2), index (4), value (16), last (1)
//   csr      in         csr_psel / csr_penable  6 byte registers, 4-byte stride
//
// A byte that completes no good frame is taken without a stall. A byte that completes good frames
// holds req_stall high while the field reader walks the buffers, one field per cycle while rsp_stall is low:
// 3, 8 or 11 fields per frame, up to 22 when all three complete at once.
// rsp_stall pauses the field reader and so keeps req_stall high for longer.
// Reset is synchronous: positions, block checks and the previous byte clear, and the
// header and tail registers return to their defaults.
`include "assert_macros.svh"

module multi_frame_serial_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_frame_kind,
   output logic [3:0]         rsp_field_index,
   output logic signed [15:0] rsp_field_value,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import dfr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       cfg_write;
   logic       req_accept;
   logic       busy;
   done_type   done;
   rd_req_type rd;
   logic [7:0] rd_hi, rd_lo;
   logic       rsp_is_final;
   logic       rsp_in_list;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (csr_paddr[4:2])
            REG_STATUS_HEADER:  cfg_in.status_header  = csr_pwdata[7:0];
            REG_STATUS_TAIL:    cfg_in.status_tail    = csr_pwdata[7:0];
            REG_RANGE_HEADER:   cfg_in.range_header   = csr_pwdata[7:0];
            REG_RANGE_TAIL:     cfg_in.range_tail     = csr_pwdata[7:0];
            REG_CHARGER_HEADER: cfg_in.charger_header = csr_pwdata[7:0];
            REG_CHARGER_TAIL:   cfg_in.charger_tail   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_STATUS_HEADER:  csr_prdata = {24'h0, cfg_ff.status_header};
         REG_STATUS_TAIL:    csr_prdata = {24'h0, cfg_ff.status_tail};
         REG_RANGE_HEADER:   csr_prdata = {24'h0, cfg_ff.range_header};
         REG_RANGE_TAIL:     csr_prdata = {24'h0, cfg_ff.range_tail};
         REG_CHARGER_HEADER: csr_prdata = {24'h0, cfg_ff.charger_header};
         REG_CHARGER_TAIL:   csr_prdata = {24'h0, cfg_ff.charger_tail};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dfr_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .rx_byte    (req_rx_byte),
      .cfg        (cfg_ff),
      .rd         (rd),
      .done       (done),
      .rd_hi      (rd_hi),
      .rd_lo      (rd_lo)
   );

   dfr_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .done            (done),
      .busy            (busy),
      .rd              (rd),
      .rd_hi           (rd_hi),
      .rd_lo           (rd_lo),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last        (rsp_last)
   );

   assign rsp_is_final =
      (rsp_frame_kind == KIND_STATUS  && rsp_field_index == STATUS_LAST_FIELD) ||
      (rsp_frame_kind == KIND_RANGE   && rsp_field_index == RANGE_LAST_FIELD) ||
      (rsp_frame_kind == KIND_CHARGER && rsp_field_index == CHARGER_LAST_FIELD);

   assign rsp_in_list =
      (rsp_frame_kind == KIND_STATUS  && rsp_field_index <= STATUS_LAST_FIELD) ||
      (rsp_frame_kind == KIND_RANGE   && rsp_field_index <= RANGE_LAST_FIELD) ||
      (rsp_frame_kind == KIND_CHARGER && rsp_field_index <= CHARGER_LAST_FIELD);

   // The last flag marks exactly the final field of each frame's list.
   `ASSERT_IMPLIES(a_last_on_final, clock, reset, rsp_valid, rsp_last == rsp_is_final)

   // A field index never runs past its frame's list.
   `ASSERT_NEVER(a_index_in_list, clock, reset, rsp_valid && !rsp_in_list)

   // The field reader only starts right after a request was taken.
   `ASSERT_IMPLIES(a_busy_after_request, clock, reset, $rose(req_stall), $past(req_valid && !req_stall))

endmodule
